>>> sv/btpc_pkg.sv
package btpc_pkg;

  typedef struct packed {
    logic        opcode;
    logic [18:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] measured_value;
    logic        divide_fault;
  } out_item_t;

  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic [31:0] TEMP_OFFSET = 32'd4000;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] FINAL_MG    = 32'd3038;
  localparam logic [31:0] FINAL_MH    = 32'hFFFF_E343; // -7357
  localparam logic [31:0] FINAL_MI    = 32'd3791;

  // datapath micro-operations, one per sequencer step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_T_X1,      // x1 = (ut-ac6)*ac5 >>> 15
    OP_T_DIVSET,  // start signed divide mc<<11 / (x1+md)
    OP_T_B5,      // b5 = x1 + q, store, result
    OP_P_B6,      // b6 = b5-4000
    OP_P_SQ,      // sq = b6*b6 >>> 12
    OP_P_M1,      // t = b2*sq >>> 11
    OP_P_M2,      // x3 = t + (ac2*b6 >>> 11)
    OP_P_B3,      // b3
    OP_P_M3,      // t = ac3*b6 >>> 13
    OP_P_M4,      // x3 = (t + (b1*sq>>>16) + 2) >>> 2
    OP_P_B4,      // b4 = ac4*(x3+32768) >> 15
    OP_P_B7,      // b7 = (raw-b3)*(50000>>oss)
    OP_P_DIVSET,  // start unsigned divide
    OP_P_Q,       // p from quotient
    OP_P_F1,      // t = (p>>>8)^2
    OP_P_F2,      // t1 = t*3038 >>> 16
    OP_P_F3,      // t2 = -7357*p >>> 16
    OP_P_F4       // p final, result
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } ctl_state_t;

endpackage

>>> sv/btpc_div.sv
module btpc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  assign busy = (cnt_r != 6'd0);
  assign quotient = q_r;

  always_comb begin
    trial = {rem_r[31:0], q_r[31]} - {1'b0, dvs_r};
    rem_nxt = {rem_r[31:0], q_r[31]};
    q_nxt = {q_r[30:0], 1'b0};
    if (!trial[32]) begin
      rem_nxt = trial;
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'd32;
    end else if (busy) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule

>>> sv/btpc_datapath.sv
module btpc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  btpc_pkg::dp_cmd_t   cmd,
  output btpc_pkg::dp_stat_t  stat,
  input  logic                load,
  input  btpc_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         value,
  output logic                fault
);
  import btpc_pkg::*;

  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;
  logic [31:0] b5_r, b5_nxt;
  logic [18:0] raw_r;
  logic [31:0] x1_r, b6_r, sq_r, t_r, x3_r, b3_r, b4_r, b7_r, p_r, t1_r;
  logic [31:0] b6_nxt, sq_nxt, t_nxt, x3_nxt, b3_nxt, b4_nxt, b7_nxt, p_nxt, t1_nxt;
  logic [31:0] x1_nxt, value_r, value_nxt;
  logic        fault_r, fault_nxt, neg_r, neg_nxt, big_r, big_nxt;

  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [31:0] pl;
  logic        div_start;
  logic [31:0] div_a, div_b, div_q;
  logic        div_busy;
  logic [31:0] dsor, dend, qs, p8, fsum;

  function automatic logic [31:0] sx(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0; ac34_r <= '0; ac56_r <= '0;
      b12_r <= '0; mcmd_r <= '0; oss_r <= '0; b5_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_AC1_AC2: ac12_r <= cfg_data;
          REG_AC3_AC4: ac34_r <= cfg_data;
          REG_AC5_AC6: ac56_r <= cfg_data;
          REG_B1_B2:   b12_r  <= cfg_data;
          REG_MC_MD:   mcmd_r <= cfg_data;
          REG_OSS:     oss_r  <= cfg_data[1:0];
          default: ;
        endcase
      end
      b5_r <= b5_nxt;
    end
  end

  // single shared 32x32 multiplier, operand select by op
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_T_X1: begin
        ma = {16'd0, raw_r[15:0]} - {16'd0, ac56_r[15:0]};
        mb = {16'd0, ac56_r[31:16]};
      end
      OP_P_SQ: begin ma = b6_r; mb = b6_r; end
      OP_P_M1: begin ma = sx(b12_r[15:0]); mb = sq_r; end
      OP_P_M2: begin ma = sx(ac12_r[15:0]); mb = b6_r; end
      OP_P_M3: begin ma = sx(ac34_r[31:16]); mb = b6_r; end
      OP_P_M4: begin ma = sx(b12_r[31:16]); mb = sq_r; end
      OP_P_B4: begin ma = {16'd0, ac34_r[15:0]}; mb = x3_r + B4_OFFSET; end
      OP_P_B7: begin ma = {13'd0, raw_r} - b3_r; mb = B7_SCALE >> oss_r; end
      OP_P_F1: begin ma = p8; mb = p8; end
      OP_P_F2: begin ma = t_r; mb = FINAL_MG; end
      OP_P_F3: begin ma = FINAL_MH; mb = p_r; end
      default: ;
    endcase
    prod = {32'd0, ma} * {32'd0, mb};
    pl = prod[31:0];
  end

  assign p8 = $signed(p_r) >>> 8;
  assign dsor = x1_r + sx(mcmd_r[15:0]);
  assign dend = sx(mcmd_r[31:16]) << 11;
  assign qs = (neg_r) ? (32'd0 - div_q) : div_q;

  always_comb begin
    b5_nxt = b5_r; x1_nxt = x1_r; b6_nxt = b6_r; sq_nxt = sq_r; t_nxt = t_r;
    x3_nxt = x3_r; b3_nxt = b3_r; b4_nxt = b4_r; b7_nxt = b7_r; p_nxt = p_r;
    t1_nxt = t1_r; value_nxt = value_r; fault_nxt = fault_r; neg_nxt = neg_r;
    big_nxt = big_r; div_start = 1'b0; div_a = '0; div_b = '0; fsum = '0;
    case (cmd.op)
      OP_T_X1: x1_nxt = $signed(pl) >>> 15;
      OP_T_DIVSET: begin
        div_start = 1'b1;
        div_a = dend[31] ? (32'd0 - dend) : dend;
        div_b = dsor[31] ? (32'd0 - dsor) : dsor;
        neg_nxt = dend[31] ^ dsor[31];
        fault_nxt = (dsor == 32'd0);
      end
      OP_T_B5: begin
        b5_nxt = x1_r + (fault_r ? 32'd0 : qs);
        value_nxt = $signed(b5_nxt + 32'd8) >>> 4;
      end
      OP_P_B6: begin b6_nxt = b5_r - TEMP_OFFSET; fault_nxt = 1'b0; end
      OP_P_SQ: sq_nxt = $signed(pl) >>> 12;
      OP_P_M1: t_nxt = $signed(pl) >>> 11;
      OP_P_M2: x3_nxt = $signed(t_r) + ($signed(pl) >>> 11);
      OP_P_B3: b3_nxt = $signed(((sx(ac12_r[31:16]) << 2) + x3_r << oss_r) + 32'd2) >>> 2;
      OP_P_M3: t_nxt = $signed(pl) >>> 13;
      OP_P_M4: x3_nxt = $signed($signed(t_r) + ($signed(pl) >>> 16) + 32'sd2) >>> 2;
      OP_P_B4: b4_nxt = pl >> 15;
      OP_P_B7: b7_nxt = pl;
      OP_P_DIVSET: begin
        div_start = 1'b1;
        big_nxt = b7_r[31];
        div_a = b7_r[31] ? b7_r : (b7_r << 1);
        div_b = b4_r;
        neg_nxt = 1'b0;
        fault_nxt = (b4_r == 32'd0);
      end
      OP_P_Q: p_nxt = fault_r ? 32'd0 : (big_r ? (div_q << 1) : div_q);
      OP_P_F1: t_nxt = pl;
      OP_P_F2: t1_nxt = $signed(pl) >>> 16;
      OP_P_F3: t_nxt = $signed(pl) >>> 16;
      OP_P_F4: begin
        fsum = t1_r + t_r + FINAL_MI;
        value_nxt = $signed(p_r) + ($signed(fsum) >>> 4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) raw_r <= in_item.raw_reading;
    x1_r <= x1_nxt; b6_r <= b6_nxt; sq_r <= sq_nxt; t_r <= t_nxt; x3_r <= x3_nxt;
    b3_r <= b3_nxt; b4_r <= b4_nxt; b7_r <= b7_nxt; p_r <= p_nxt; t1_r <= t1_nxt;
    value_r <= value_nxt; fault_r <= fault_nxt; neg_r <= neg_nxt; big_r <= big_nxt;
  end

  btpc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  assign stat.div_busy = div_busy;
  assign value = value_r;
  assign fault = fault_r;
endmodule

>>> sv/btpc_ctrl.sv
module btpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic                load,
  output btpc_pkg::dp_cmd_t   cmd,
  input  btpc_pkg::dp_stat_t  stat
);
  import btpc_pkg::*;

  ctl_state_t state_r, state_nxt;
  dp_op_t op_r, op_nxt;
  logic kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_NOP;
      kind_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    kind_nxt = kind_r;
    in_ready = (state_r == ST_IDLE);
    load = 1'b0;
    out_valid = (state_r == ST_OUT);
    cmd.op = OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load = 1'b1;
          kind_nxt = in_opcode;
          op_nxt = in_opcode ? OP_P_B6 : OP_T_X1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.op = op_r;
        case (op_r)
          OP_T_DIVSET, OP_P_DIVSET: begin
            op_nxt = (op_r == OP_T_DIVSET) ? OP_T_B5 : OP_P_Q;
            state_nxt = ST_WAIT;
          end
          OP_T_B5, OP_P_F4: state_nxt = ST_OUT;
          default: op_nxt = dp_op_t'(op_r + 5'd1);
        endcase
      end
      ST_WAIT: begin
        // quotient is final in the cycle busy drops
        if (!stat.div_busy) state_nxt = ST_RUN;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_kind = kind_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept during result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && (op_r == OP_T_DIVSET || op_r == OP_P_DIVSET)) |=> stat.div_busy)
    else $error("divider not started");
endmodule

>>> sv/baro_temp_pressure_compensation.sv
// channel | signals                          | transfer when
// in      | in_valid in_ready in_data        | in_valid && in_ready
// out     | out_valid out_ready out_data     | out_valid && out_ready
// cfg     | cfg_we cfg_index cfg_data        | cfg_we
// one item at a time through a sequencer over one shared multiplier
// temperature and pressure items both wait on the 32-step divider
// reset clears coefficients, stored b5 and control
// a stalled result holds the block; no new item is taken until it transfers
module baro_temp_pressure_compensation (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btpc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import btpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic load, kind, fault;
  logic [31:0] value;

  btpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_data.opcode), .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(kind), .load(load), .cmd(cmd), .stat(stat)
  );

  btpc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .load(load),
    .in_item(in_data), .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .value(value), .fault(fault)
  );

  assign out_data.result_kind    = kind;
  assign out_data.measured_value = value;
  assign out_data.divide_fault   = fault;
endmodule

>>> dv/baro_temp_pressure_compensation_tb.sv
module baro_temp_pressure_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_AC1_AC2;
  logic [31:0] cfg_data = '0;

  baro_temp_pressure_compensation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // local copy of the coefficients and the stored b5
  logic [31:0] m_ac12, m_ac34, m_ac56, m_b12, m_mcmd, m_b5;
  logic [1:0]  m_oss;

  out_item_t   pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;

  typedef logic [31:0] cfg_set_t [6];
  cfg_set_t cfg_sets [5];

  typedef struct {
    int          set_no;
    logic        opcode;
    logic [18:0] raw;
    bit          typed;
    logic [31:0] value;
    logic        fault;
  } row_t;

  row_t rows [$] = '{
    '{0, 1'b0, 19'h00000, 1, 32'd0,   1'b1},
    '{0, 1'b0, 19'h7FFFF, 1, 32'd0,   1'b1},
    '{0, 1'b1, 19'h00000, 1, 32'd236, 1'b1},
    '{0, 1'b1, 19'h7FFFF, 1, 32'd236, 1'b1},
    '{1, 1'b0, 19'h06C7A, 0, 32'd0,   1'b0},
    '{1, 1'b1, 19'h05D23, 0, 32'd0,   1'b0},
    '{1, 1'b1, 19'h00000, 0, 32'd0,   1'b0},
    '{1, 1'b1, 19'h7FFFF, 0, 32'd0,   1'b0},
    '{1, 1'b0, 19'h00000, 0, 32'd0,   1'b0},
    '{1, 1'b0, 19'h0FFFF, 0, 32'd0,   1'b0},
    '{1, 1'b0, 19'h7FFFF, 0, 32'd0,   1'b0},
    '{2, 1'b0, 19'h06C7A, 0, 32'd0,   1'b0},
    '{2, 1'b1, 19'h05D23, 0, 32'd0,   1'b0},
    '{2, 1'b1, 19'h7FFFF, 0, 32'd0,   1'b0},
    '{3, 1'b0, 19'h00000, 0, 32'd0,   1'b0},
    '{3, 1'b1, 19'h00000, 0, 32'd0,   1'b0},
    '{3, 1'b1, 19'h7FFFF, 0, 32'd0,   1'b0},
    '{3, 1'b0, 19'h0FFFF, 0, 32'd0,   1'b0},
    '{4, 1'b0, 19'h08000, 0, 32'd0,   1'b0},
    '{4, 1'b1, 19'h40000, 0, 32'd0,   1'b0}
  };

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] div_signed(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic out_item_t compensate(in_item_t it);
    out_item_t   r;
    logic [31:0] ut, ac5, ac6, mc, md, x1, x2, den, b5;
    logic [31:0] ac1, ac2, ac3, ac4, b1, b2, b6, sq, x3, b3, b4, b7, p, t1, t2;
    r = '0;
    r.result_kind = it.opcode;
    if (it.opcode == 1'b0) begin
      ut  = {16'd0, it.raw_reading[15:0]};
      ac5 = {16'd0, m_ac56[31:16]};
      ac6 = {16'd0, m_ac56[15:0]};
      mc  = sext16(m_mcmd[31:16]);
      md  = sext16(m_mcmd[15:0]);
      x1  = asr((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 32'd0) begin
        r.divide_fault = 1'b1;
        x2 = '0;
      end else begin
        x2 = div_signed(mc << 11, den);
      end
      b5   = x1 + x2;
      m_b5 = b5;
      r.measured_value = asr(b5 + 32'd8, 4);
    end else begin
      ac1 = sext16(m_ac12[31:16]);
      ac2 = sext16(m_ac12[15:0]);
      ac3 = sext16(m_ac34[31:16]);
      ac4 = {16'd0, m_ac34[15:0]};
      b1  = sext16(m_b12[31:16]);
      b2  = sext16(m_b12[15:0]);
      b6  = m_b5 - TEMP_OFFSET;
      sq  = asr(b6 * b6, 12);
      x3  = asr(b2 * sq, 11) + asr(ac2 * b6, 11);
      b3  = asr(((ac1 * 32'd4 + x3) << m_oss) + 32'd2, 2);
      x3  = asr(asr(ac3 * b6, 13) + asr(b1 * sq, 16) + 32'd2, 2);
      b4  = (ac4 * (x3 + B4_OFFSET)) >> 15;
      b7  = ({13'd0, it.raw_reading} - b3) * (B7_SCALE >> m_oss);
      if (b4 == 32'd0) begin
        r.divide_fault = 1'b1;
        p = '0;
      end else if (b7 < 32'h8000_0000) begin
        p = (b7 << 1) / b4;
      end else begin
        p = (b7 / b4) << 1;
      end
      t1 = asr((asr(p, 8) * asr(p, 8)) * FINAL_MG, 16);
      t2 = asr(FINAL_MH * p, 16);
      r.measured_value = p + asr(t1 + t2 + FINAL_MI, 4);
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefs(cfg_set_t s);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= s[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_ac12 = s[REG_AC1_AC2];
    m_ac34 = s[REG_AC3_AC4];
    m_ac56 = s[REG_AC5_AC6];
    m_b12  = s[REG_B1_B2];
    m_mcmd = s[REG_MC_MD];
    m_oss  = s[REG_OSS][1:0];
  endtask

  // offer one item, keep valid high until the transfer, then predict
  task automatic offer(logic opc, logic [18:0] raw, bit typed = 0,
                       logic [31:0] value = '0, logic fault = 1'b0);
    in_item_t  it;
    out_item_t e;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    it.opcode      = opc;
    it.raw_reading = raw;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = compensate(it);
    if (typed && (e.measured_value !== value || e.divide_fault !== fault))
      report("typed row vs predictor", e.measured_value, value);
    if (typed) begin
      e.measured_value = value;
      e.divide_fault   = fault;
    end
    pending_q.push_back(e);
  endtask

  function automatic cfg_set_t random_coefs();
    cfg_set_t s;
    int       mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 5; i++) begin
      case (mode)
        0: s[i] = $urandom;
        1: s[i] = cfg_sets[1][i];
        2: begin
          case ($urandom_range(0, 3))
            0: s[i] = 32'hFFFF_FFFF;
            1: s[i] = 32'h8000_8000;
            2: s[i] = 32'h7FFF_7FFF;
            default: s[i] = 32'h0000_0000;
          endcase
        end
        default: s[i] = cfg_sets[1][i] ^ ($urandom & 32'h00FF_00FF);
      endcase
    end
    s[REG_OSS] = 32'($urandom_range(0, 3));
    return s;
  endfunction

  // result side
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_data.measured_value, 32'd0);
      end else begin
        e = pending_q.pop_front();
        if (out_data.result_kind !== e.result_kind)
          report("result_kind", 32'(out_data.result_kind), 32'(e.result_kind));
        if (out_data.measured_value !== e.measured_value)
          report("measured_value", out_data.measured_value, e.measured_value);
        if (out_data.divide_fault !== e.divide_fault)
          report("divide_fault", 32'(out_data.divide_fault), 32'(e.divide_fault));
      end
    end
  end

  initial begin
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int       cur_set;
    cfg_set_t s;
    cfg_sets[0] = '{default: 32'd0};
    cfg_sets[1] = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71,
                    32'h182E_0004, 32'hDDF9_0B34, 32'd0};
    cfg_sets[2] = cfg_sets[1];
    cfg_sets[2][REG_OSS] = 32'd3;
    cfg_sets[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3};
    cfg_sets[4] = '{32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                    32'h7FFF_7FFF, 32'h8000_7FFF, 32'd1};
    m_ac12 = '0; m_ac34 = '0; m_ac56 = '0; m_b12 = '0; m_mcmd = '0;
    m_oss = '0; m_b5 = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_set = 0;
    foreach (rows[i]) begin
      if (rows[i].set_no != cur_set) begin
        in_valid <= 1'b0;
        wait_drained();
        cur_set = rows[i].set_no;
        load_coefs(cfg_sets[cur_set]);
      end
      offer(rows[i].opcode, rows[i].raw, rows[i].typed, rows[i].value, rows[i].fault);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      s = random_coefs();
      load_coefs(s);
      if (ph == 3) long_hold = 1'b1;
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly a temperature transfer followed by a pressure one
        if ($urandom_range(0, 9) < 6) begin
          offer(1'b0, 19'($urandom));
          offer(1'b1, 19'($urandom));
          n++;
        end else begin
          offer(1'($urandom), 19'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
